FILE: sv/lru_keyed_slot_cache_macros.svh
// assertion macros shared by the checker of the slot cache
`ifndef LRU_KEYED_SLOT_CACHE_MACROS_SVH
`define LRU_KEYED_SLOT_CACHE_MACROS_SVH

// clocked assertion on clk_i, off while rst_ni is low
`define LKSC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lksc assertion failed");

// implication into the next cycle
`define LKSC_ASSERT_NEXT(label, pre, post) \
  `LKSC_ASSERT(label, (pre) |=> (post))

// same-cycle implication
`define LKSC_ASSERT_NOW(label, pre, post) \
  `LKSC_ASSERT(label, (pre) |-> (post))

`endif

FILE: sv/lksc_pkg.sv
// types, codes and defaults of the keyed slot cache
package lksc_pkg;

  localparam int unsigned SlotsDef    = 16;
  localparam int unsigned KeyBytesDef = 8;
  localparam int unsigned DataBitsDef = 32;

  localparam int unsigned KeyInW   = 64;
  localparam int unsigned HandleW  = 32;
  localparam int unsigned SlotIdxW = 4;
  localparam int unsigned StampW   = 32;

  localparam logic [StampW-1:0] FrameReset = 32'd1;

  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_PUT    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_FRAME  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_MISS   = 2'd1,
    ST_REJECT = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_e;

  typedef struct packed {
    op_e                 operation;
    logic [KeyInW-1:0]   key;
    logic [HandleW-1:0]  data_handle;
    logic                data_valid;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic [HandleW-1:0]  data_out;
    logic                release_res;
    logic [SlotIdxW-1:0] slot_index;
  } rsp_t;

endpackage

FILE: sv/lksc_chan_if.sv
// valid/ready channel carrying one payload struct
interface lksc_chan_if #(
  parameter type payload_t = lksc_pkg::req_t
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: sv/lru_keyed_slot_cache.sv
// fully associative lru cache of keyed slots, scanned by one shared compare unit
//
//   channel  dir  payload       handshake
//   req_i    in   lksc_pkg::req_t  valid/ready, taken when both high
//   rsp_o    out  lksc_pkg::rsp_t  valid/ready, taken when both high
//
// get, put and remove scan every slot through one key/stamp compare stage, one slot
// per cycle off the single read port; after the scan state comes a drain state, then
// the done state registers the result, and the next request is taken back in idle.
// begin-frame and rejected puts skip the scan and go straight to the done state.
// reset clears all valid bits at once and sets the frame counter to one.
// a held result does not block the next request; its write-back waits while one is held.
module lru_keyed_slot_cache #(
  parameter int unsigned SLOTS     = lksc_pkg::SlotsDef,
  parameter int unsigned KEY_BYTES = lksc_pkg::KeyBytesDef,
  parameter int unsigned DATA_BITS = lksc_pkg::DataBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lksc_chan_if.sink   req_i,
  lksc_chan_if.source rsp_o
);

  localparam int unsigned IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned KW   = 8 * KEY_BYTES;
  localparam int unsigned OutW = lksc_pkg::HandleW;
  localparam int unsigned DW   = (DATA_BITS < OutW) ? DATA_BITS : OutW;
  localparam int unsigned SW   = lksc_pkg::StampW;
  localparam int unsigned XW   = lksc_pkg::SlotIdxW;

  // slot memories
  logic [KW-1:0] key_mem   [SLOTS];
  logic [DW-1:0] data_mem  [SLOTS];
  logic [SW-1:0] stamp_mem [SLOTS];
  logic [SLOTS-1:0] valid_q;

  lksc_pkg::state_e state_q, state_d;
  logic [SW-1:0] frame_q;

  // latched request
  lksc_pkg::op_e op_q;
  logic [KW-1:0] key_q;
  logic [DW-1:0] handle_q;
  logic          dv_q;

  // scan pipeline
  logic [IW-1:0] issue_q;
  logic          cmp_vld_q;
  logic [IW-1:0] cmp_idx_q;
  logic [KW-1:0] rd_key_q;
  logic [DW-1:0] rd_data_q;
  logic [SW-1:0] rd_stamp_q;

  // scan results
  logic          hit_q, free_q;
  logic [IW-1:0] hit_idx_q, free_idx_q, best_idx_q;
  logic [DW-1:0] hit_data_q, best_data_q;
  logic [SW-1:0] best_stamp_q;

  logic rsp_valid_q;
  lksc_pkg::rsp_t rsp_q, rsp_d;

  logic req_ready, accept, issue_en, done_fire;
  logic cmp_match, cmp_free, cmp_better;

  // write-back controls
  lksc_pkg::status_e st_d;
  logic [DW-1:0] dout_d;
  logic          rel_d;
  logic [IW-1:0] idx_d, wr_addr;
  logic we_key, we_data, we_stamp, set_v, clr_v, frame_inc;

  assign req_i.ready   = req_ready;
  assign accept        = req_i.valid && req_ready;
  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  always_comb begin
    state_d   = state_q;
    req_ready = 1'b0;
    issue_en  = 1'b0;
    done_fire = 1'b0;
    case (state_q)
      lksc_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_i.valid) begin
          if (req_i.payload.operation == lksc_pkg::OP_FRAME ||
              (req_i.payload.operation == lksc_pkg::OP_PUT && !req_i.payload.data_valid)) begin
            state_d = lksc_pkg::S_DONE;
          end else begin
            state_d = lksc_pkg::S_SCAN;
          end
        end
      end
      lksc_pkg::S_SCAN: begin
        issue_en = 1'b1;
        if (issue_q == IW'(SLOTS - 1)) begin
          state_d = lksc_pkg::S_DRAIN;
        end
      end
      lksc_pkg::S_DRAIN: begin
        state_d = lksc_pkg::S_DONE;
      end
      lksc_pkg::S_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          done_fire = 1'b1;
          state_d   = lksc_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = lksc_pkg::S_IDLE;
      end
    endcase
  end

  // shared compare stage, one slot per cycle
  assign cmp_match  = valid_q[cmp_idx_q] && (rd_key_q == key_q);
  assign cmp_free   = !valid_q[cmp_idx_q];
  assign cmp_better = (cmp_idx_q == '0) || (rd_stamp_q < best_stamp_q);

  always_comb begin
    st_d      = lksc_pkg::ST_OK;
    dout_d    = '0;
    rel_d     = 1'b0;
    idx_d     = '0;
    wr_addr   = hit_idx_q;
    we_key    = 1'b0;
    we_data   = 1'b0;
    we_stamp  = 1'b0;
    set_v     = 1'b0;
    clr_v     = 1'b0;
    frame_inc = 1'b0;
    case (op_q)
      lksc_pkg::OP_FRAME: begin
        frame_inc = 1'b1;
      end
      lksc_pkg::OP_GET: begin
        if (hit_q) begin
          dout_d   = hit_data_q;
          idx_d    = hit_idx_q;
          we_stamp = 1'b1;
        end else begin
          st_d = lksc_pkg::ST_MISS;
        end
      end
      lksc_pkg::OP_REMOVE: begin
        if (hit_q) begin
          dout_d = hit_data_q;
          rel_d  = 1'b1;
          idx_d  = hit_idx_q;
          clr_v  = 1'b1;
        end else begin
          st_d = lksc_pkg::ST_MISS;
        end
      end
      lksc_pkg::OP_PUT: begin
        if (!dv_q) begin
          st_d = lksc_pkg::ST_REJECT;
        end else if (hit_q) begin
          dout_d   = hit_data_q;
          rel_d    = 1'b1;
          idx_d    = hit_idx_q;
          we_data  = 1'b1;
          we_stamp = 1'b1;
        end else if (free_q) begin
          idx_d    = free_idx_q;
          wr_addr  = free_idx_q;
          we_key   = 1'b1;
          we_data  = 1'b1;
          we_stamp = 1'b1;
          set_v    = 1'b1;
        end else begin
          // cache full: evict the oldest stamp
          dout_d   = best_data_q;
          rel_d    = 1'b1;
          idx_d    = best_idx_q;
          wr_addr  = best_idx_q;
          we_key   = 1'b1;
          we_data  = 1'b1;
          we_stamp = 1'b1;
        end
      end
      default: begin
      end
    endcase
    rsp_d.status      = st_d;
    rsp_d.data_out    = OutW'(dout_d);
    rsp_d.release_res = rel_d;
    rsp_d.slot_index  = XW'(idx_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lksc_pkg::S_IDLE;
      frame_q     <= lksc_pkg::FrameReset;
      valid_q     <= '0;
      issue_q     <= '0;
      cmp_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= issue_en;
      if (accept) begin
        issue_q <= '0;
        hit_q   <= 1'b0;
        free_q  <= 1'b0;
      end else begin
        if (issue_en) begin
          issue_q <= issue_q + 1'b1;
        end
        if (cmp_vld_q && cmp_match) begin
          hit_q <= 1'b1;
        end
        if (cmp_vld_q && cmp_free) begin
          free_q <= 1'b1;
        end
      end
      if (done_fire) begin
        rsp_valid_q <= 1'b1;
        if (frame_inc) begin
          frame_q <= frame_q + 1'b1;
        end
        if (set_v) begin
          valid_q[wr_addr] <= 1'b1;
        end
        if (clr_v) begin
          valid_q[wr_addr] <= 1'b0;
        end
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // payload registers and scan results
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= req_i.payload.operation;
      key_q    <= req_i.payload.key[KW-1:0];
      handle_q <= req_i.payload.data_handle[DW-1:0];
      dv_q     <= req_i.payload.data_valid;
    end
    cmp_idx_q <= issue_q;
    if (cmp_vld_q) begin
      // first match and first free slot win
      if (cmp_match && !hit_q) begin
        hit_idx_q  <= cmp_idx_q;
        hit_data_q <= rd_data_q;
      end
      if (cmp_free && !free_q) begin
        free_idx_q <= cmp_idx_q;
      end
      if (cmp_better) begin
        best_stamp_q <= rd_stamp_q;
        best_idx_q   <= cmp_idx_q;
        best_data_q  <= rd_data_q;
      end
    end
    if (done_fire) begin
      rsp_q <= rsp_d;
    end
  end

  // slot memories: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (done_fire && we_key) begin
      key_mem[wr_addr] <= key_q;
    end
    if (done_fire && we_data) begin
      data_mem[wr_addr] <= handle_q;
    end
    if (done_fire && we_stamp) begin
      stamp_mem[wr_addr] <= frame_q;
    end
    if (issue_en) begin
      rd_key_q   <= key_mem[issue_q];
      rd_data_q  <= data_mem[issue_q];
      rd_stamp_q <= stamp_mem[issue_q];
    end
  end

endmodule

FILE: sv/lksc_checker.sv
// port-level checker of the keyed slot cache, bound to the top level
`include "lru_keyed_slot_cache_macros.svh"

module lksc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [1:0]  rsp_status_i,
  input logic [31:0] rsp_data_i,
  input logic        rsp_release_i
);

  // a held result keeps its payload
  `LKSC_ASSERT_NEXT(rsp_hold_a, rsp_valid_i && !rsp_ready_i,
                    rsp_valid_i && $stable(rsp_data_i) && $stable(rsp_status_i))

  // one request at a time: ready drops after a request is taken
  `LKSC_ASSERT_NEXT(one_at_a_time_a, req_valid_i && req_ready_i, !req_ready_i)

  // a miss or a reject carries no handle
  `LKSC_ASSERT_NOW(miss_empty_a, rsp_valid_i && rsp_status_i != lksc_pkg::ST_OK,
                   rsp_data_i == '0 && !rsp_release_i)

  // a handle to release only comes with a successful request
  `LKSC_ASSERT_NOW(release_ok_a, rsp_valid_i && rsp_release_i,
                   rsp_status_i == lksc_pkg::ST_OK)

endmodule

bind lru_keyed_slot_cache lksc_checker u_lksc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_status_i  (rsp_o.payload.status),
  .rsp_data_i    (rsp_o.payload.data_out),
  .rsp_release_i (rsp_o.payload.release_res)
);
